### rtl/integral_image_box_sum_top_defines.svh
// Assertion macros shared by the integral image box sum RTL.
// Needs nothing else; the modules that check their own logic include it.
`ifndef INTEGRAL_IMAGE_BOX_SUM_TOP_DEFINES_SVH
`define INTEGRAL_IMAGE_BOX_SUM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IIBS_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IIBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iibs_pkg.sv
// Package for the integral image box sum block: payload types, the command
// passed from the front end to the back end, and shared constants.
package iibs_pkg;

    localparam int VALUE_W          = 20;
    localparam int COORD_W          = 8;   // covers every row or column up to 255
    localparam int SIDE_W           = 7;
    localparam int MAX_SIDE_DEFAULT = 64;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    localparam int NTERMS = 4;
    localparam int TIDX_W = $clog2(NTERMS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_IMAGE_SIDE = 1'b0;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
        logic [5:0] top_row;
        logic [5:0] left_col;
        logic [5:0] bottom_row;
        logic [5:0] right_col;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               bad_query;
    } out_item_t;

    // One classified item: up to four signed table terms plus a constant.
    typedef struct packed {
        logic [NTERMS-1:0][COORD_W-1:0] term_row;
        logic [NTERMS-1:0][COORD_W-1:0] term_col;
        logic [NTERMS-1:0]              term_en;
        logic [NTERMS-1:0]              term_neg;
        logic [VALUE_W-1:0]             base;
        logic                           is_load;
        logic [COORD_W-1:0]             wr_row;
        logic [COORD_W-1:0]             wr_col;
        logic                           bad_query;
    } cmd_t;

endpackage

### rtl/iibs_front.sv
// Front end: accepts items, tracks the raster load position, checks query
// corners and turns each item into a table command. Uses iibs_pkg.
`include "integral_image_box_sum_top_defines.svh"

module iibs_front #(
    parameter int MAX_SIDE = iibs_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [iibs_pkg::SIDE_W-1:0]     side,
    input  logic                            restart,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  iibs_pkg::in_item_t              item,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output iibs_pkg::cmd_t                  cmd
);
    import iibs_pkg::*;

    localparam int PW = $clog2(MAX_SIDE);
    localparam int SW = (PW + 1 > SIDE_W) ? PW + 1 : SIDE_W;

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [SW-1:0] side_eff;
    logic [SW-1:0] row_p1, col_p1;
    logic          load_fire;
    logic          bad;
    logic [COORD_W-1:0] r_c, c_c, t_c, l_c, b_c, rc_c;

    assign item_ready = cmd_ready;
    assign cmd_valid  = item_valid;
    assign load_fire  = item_valid && cmd_ready && (item.op == OP_LOAD);

    // A side of zero acts as one; anything above the table size is clamped.
    always_comb
    begin
        priority if (side == '0)
        begin
            side_eff = SW'(1);
        end
        else if (SW'(side) > SW'(MAX_SIDE))
        begin
            side_eff = SW'(MAX_SIDE);
        end
        else
        begin
            side_eff = SW'(side);
        end
    end

    assign row_p1 = SW'(row_reg) + SW'(1);
    assign col_p1 = SW'(col_reg) + SW'(1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (col_p1 >= side_eff)
        begin
            col_next = '0;
            row_next = (row_p1 >= side_eff) ? '0 : PW'(row_p1);
        end
        else
        begin
            col_next = PW'(col_p1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (restart)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (load_fire)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign r_c  = COORD_W'(row_reg);
    assign c_c  = COORD_W'(col_reg);
    assign t_c  = COORD_W'(item.top_row);
    assign l_c  = COORD_W'(item.left_col);
    assign b_c  = COORD_W'(item.bottom_row);
    assign rc_c = COORD_W'(item.right_col);

    assign bad = (SW'(item.top_row) >= side_eff) || (SW'(item.left_col) >= side_eff)
              || (SW'(item.bottom_row) >= side_eff) || (SW'(item.right_col) >= side_eff)
              || (item.top_row > item.bottom_row) || (item.left_col > item.right_col);

    always_comb
    begin
        cmd = '0;
        unique case (item.op)
            OP_LOAD:
            begin
                // top + left - top_left + pixel
                cmd.term_row[1] = r_c - COORD_W'(1);
                cmd.term_col[1] = c_c;
                cmd.term_en[1]  = (row_reg != '0);
                cmd.term_row[2] = r_c;
                cmd.term_col[2] = c_c - COORD_W'(1);
                cmd.term_en[2]  = (col_reg != '0);
                cmd.term_row[3] = r_c - COORD_W'(1);
                cmd.term_col[3] = c_c - COORD_W'(1);
                cmd.term_en[3]  = (row_reg != '0) && (col_reg != '0);
                cmd.term_neg[3] = 1'b1;
                cmd.base        = VALUE_W'(item.pixel);
                cmd.is_load     = 1'b1;
                cmd.wr_row      = r_c;
                cmd.wr_col      = c_c;
            end
            OP_QUERY:
            begin
                if (bad)
                begin
                    cmd.bad_query = 1'b1;
                end
                else
                begin
                    cmd.term_row[0] = b_c;
                    cmd.term_col[0] = rc_c;
                    cmd.term_en[0]  = 1'b1;
                    cmd.term_row[1] = t_c - COORD_W'(1);
                    cmd.term_col[1] = rc_c;
                    cmd.term_en[1]  = (item.top_row != '0);
                    cmd.term_neg[1] = 1'b1;
                    cmd.term_row[2] = b_c;
                    cmd.term_col[2] = l_c - COORD_W'(1);
                    cmd.term_en[2]  = (item.left_col != '0);
                    cmd.term_neg[2] = 1'b1;
                    cmd.term_row[3] = t_c - COORD_W'(1);
                    cmd.term_col[3] = l_c - COORD_W'(1);
                    cmd.term_en[3]  = (item.top_row != '0) && (item.left_col != '0);
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `IIBS_ASSERT(a_pos_in_frame, clk, rst_n, 1'b1, (SW'(row_reg) < side_eff) && (SW'(col_reg) < side_eff), "load position left the frame")

endmodule

### rtl/iibs_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses cmd_t and the queue sizes from iibs_pkg.
`include "integral_image_box_sum_top_defines.svh"

module iibs_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  iibs_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output iibs_pkg::cmd_t pop_data
);
    import iibs_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push_fire, pop_fire;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `IIBS_ASSERT(a_q_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QDEPTH), "queue count above depth")
    `IIBS_ASSERT_NEXT(a_q_grow, clk, rst_n, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

### rtl/iibs_back.sv
// Back end: holds the summed-area table memory, reads the terms of one
// command in turn, accumulates them, writes loads back and takes no new command until done. Uses iibs_pkg.
`include "integral_image_box_sum_top_defines.svh"

module iibs_back #(
    parameter int MAX_SIDE = iibs_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  iibs_pkg::cmd_t        cmd,
    output logic                  result_valid,
    input  logic                  result_ready,
    output iibs_pkg::out_item_t   result
);
    import iibs_pkg::*;

    localparam int PW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * PW;
    localparam int DEPTH = 1 << AW;
    localparam int STW   = TIDX_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [STW-1:0] STEP_LAST = STW'(NTERMS);

    logic [VALUE_W-1:0] sat_mem [DEPTH];

    logic [1:0]         state_reg, state_next;
    logic [STW-1:0]     step_reg, step_next;
    cmd_t               cmd_reg;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               rd_use_reg, rd_neg_reg;
    logic               result_valid_reg, result_valid_next;
    out_item_t          result_reg;

    logic               slot_free;
    logic               rd_en, wr_en, take;
    logic [TIDX_W-1:0]  tidx;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [VALUE_W-1:0] contrib;

    assign slot_free = !result_valid_reg || result_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign tidx      = step_reg[TIDX_W-1:0];
    assign rd_en     = (state_reg == ST_READ) && (step_reg < STEP_LAST);
    assign wr_en     = (state_reg == ST_FINISH) && slot_free && cmd_reg.is_load;
    assign rd_addr   = {cmd_reg.term_row[tidx][PW-1:0], cmd_reg.term_col[tidx][PW-1:0]};
    assign wr_addr   = {cmd_reg.wr_row[PW-1:0], cmd_reg.wr_col[PW-1:0]};
    assign contrib   = rd_use_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sat_mem[wr_addr] <= acc_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= sat_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        acc_next          = acc_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    acc_next   = cmd.base;
                    step_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // The read issued last step lands now and joins the sum.
                if (step_reg != '0)
                begin
                    acc_next = rd_neg_reg ? acc_reg - contrib : acc_reg + contrib;
                end
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
            rd_use_reg       <= 1'b0;
            rd_neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
            rd_use_reg       <= rd_en && cmd_reg.term_en[tidx];
            rd_neg_reg       <= rd_en && cmd_reg.term_neg[tidx];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (take)
        begin
            cmd_reg <= cmd;
        end
        if ((state_reg == ST_FINISH) && slot_free)
        begin
            result_reg.value     <= acc_reg;
            result_reg.bad_query <= cmd_reg.bad_query;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `IIBS_ASSERT(a_step_range, clk, rst_n, 1'b1, step_reg <= STEP_LAST, "term step out of range")
    `IIBS_ASSERT(a_bad_zero, clk, rst_n, result_valid_reg && result_reg.bad_query, result_reg.value == '0, "rejected query with nonzero value")
    `IIBS_ASSERT_NEXT(a_finish_out, clk, rst_n, (state_reg == ST_FINISH) && slot_free, result_valid_reg && (result_reg.value == $past(acc_reg)), "finished sum not presented")

endmodule

### rtl/integral_image_box_sum_top.sv
// Top level of the integral image box sum block: configuration registers,
// front end, command queue and back end. Uses iibs_pkg and the iibs_* modules.
//
//  Channel   Handshake                      Payload
//  -------   -----------------------------  -----------------------------
//  item      item_valid / item_ready        item   (in_item_t)
//  result    result_valid / result_ready    result (out_item_t)
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// For each item the back end takes the command from the queue, streams four
// table reads through the single memory port and sums them, then writes a load
// back and registers the result; it takes no new command until it is done.
// The front end takes an item in the cycle it arrives while the queue has room,
// so up to two classified items wait while the back end works.
// A finished result sits in the output register and the back end holds only
// when that register is still occupied.
// Reset clears the load position, the queue and all handshake state and sets
// image_side to 64; the table memory is not cleared.
module integral_image_box_sum_top #(
    parameter int MAX_SIDE = iibs_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  iibs_pkg::in_item_t            item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output iibs_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iibs_pkg::PADDR_W-1:0]  paddr,
    input  logic [iibs_pkg::PDATA_W-1:0]  pwdata,
    output logic [iibs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import iibs_pkg::*;

    logic [SIDE_W-1:0] side_reg;
    logic              cfg_wr;
    logic              reg_idx;
    logic              front_valid, front_ready;
    cmd_t              front_cmd;
    logic              back_valid, back_ready;
    cmd_t              back_cmd;

    // Register i sits at byte address 4*i, so the index is the word address.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_IMAGE_SIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            side_reg <= pwdata[SIDE_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_IMAGE_SIDE) ? PDATA_W'(side_reg) : '0;

    // Writing the side also sends the next pixel back to the first position.
    iibs_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_reg),
        .restart    (cfg_wr),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    iibs_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    iibs_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### bench/tb_integral_image_box_sum_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for integral_image_box_sum_top: pixel loads and box-sum queries
// are checked against a behavioral summed-area table kept in a scoreboard class.
// Depends on iibs_pkg and the integral image box sum RTL only.

module tb_integral_image_box_sum_top;

    import iibs_pkg::*;

    // The table is addressed with a fixed row stride of the largest side.
    localparam int TABLE_SIDE = MAX_SIDE_DEFAULT;

    // Idle wait after the last result, so that any work still in flight can settle.
    localparam int SETTLE_CYCLES = 10;

    // Cycles without any transfer on any channel before the run is declared hung.
    // The slowest legal stretch is a sender gap, the back-end latency and the longest
    // receiver stall back to back, well under this limit.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int RANDOM_ITEMS = 1100;

    localparam logic [PADDR_W-1:0] SIDE_ADDR = PADDR_W'(4 * REG_IMAGE_SIDE);

    // Receiver behaviors that alternate during the run.
    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_LONG_STALL,
        RX_TOGGLE
    } rx_mode_t;

    // Scoreboard: keeps its own summed-area table, predicts the result of every
    // accepted item and matches results in order against those predictions.
    class box_sum_scoreboard;
        logic [VALUE_W-1:0] sum_table [TABLE_SIDE][TABLE_SIDE];
        int unsigned        side;
        int unsigned        load_row;
        int unsigned        load_col;
        bit                 frame_ready;
        out_item_t          expected_results [$];
        int unsigned        fail_count;
        int unsigned        checked_count;
        int unsigned        load_count;
        int unsigned        query_count;
        int unsigned        rejected_count;

        function new();
            foreach (sum_table[r, c])
                sum_table[r][c] = '0;
            side           = TABLE_SIDE;
            load_row       = 0;
            load_col       = 0;
            frame_ready    = 1'b0;
            fail_count     = 0;
            checked_count  = 0;
            load_count     = 0;
            query_count    = 0;
            rejected_count = 0;
        endfunction

        // A side of zero behaves as one, anything above the table size as the full table.
        // Every write restarts loading at the top-left pixel.
        function void set_side(logic [SIDE_W-1:0] side_word);
            if (side_word == 0)
                side = 1;
            else if (side_word > TABLE_SIDE)
                side = TABLE_SIDE;
            else
                side = side_word;
            load_row    = 0;
            load_col    = 0;
            frame_ready = 1'b0;
        endfunction

        // Integral value at (r1-1, c1-1), the sum above and left of (r1, c1); row or column zero lies outside.
        function logic [VALUE_W-1:0] corner(int unsigned r1, int unsigned c1);
            if (r1 == 0 || c1 == 0)
                return '0;
            return sum_table[r1-1][c1-1];
        endfunction

        function void note_item(in_item_t it);
            out_item_t   want;
            int unsigned r;
            int unsigned c;
            int unsigned t;
            int unsigned l;
            int unsigned b;
            int unsigned rc;

            want = '0;
            if (it.op == OP_LOAD) begin
                r = load_row;
                c = load_col;
                // Top plus left minus top-left plus the new pixel, all modulo 2^20.
                want.value = corner(r, c + 1) + corner(r + 1, c) - corner(r, c)
                             + VALUE_W'(it.pixel);
                sum_table[r][c] = want.value;
                c++;
                if (c >= side) begin
                    c = 0;
                    r++;
                    if (r >= side)
                        r = 0;
                end
                load_row    = r;
                load_col    = c;
                // Queries are only legal once every entry of the frame has been written.
                frame_ready = (r == 0 && c == 0);
                load_count++;
            end
            else begin
                t  = it.top_row;
                l  = it.left_col;
                b  = it.bottom_row;
                rc = it.right_col;
                query_count++;
                if (t >= side || l >= side || b >= side || rc >= side || t > b || l > rc) begin
                    want.bad_query = 1'b1;
                    rejected_count++;
                end
                else begin
                    want.value = corner(b + 1, rc + 1) - corner(t, rc + 1)
                                 - corner(b + 1, l) + corner(t, l);
                end
            end
            expected_results.push_back(want);
        endfunction

        task report(string msg);
            if (fail_count < 40)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;

            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing expected: value %0d bad_query %0b",
                                 got.value, got.bad_query));
                return;
            end
            want = expected_results.pop_front();
            checked_count++;
            if (got.value !== want.value)
                report($sformatf("result %0d value %0d, expected %0d",
                                 checked_count, got.value, want.value));
            if (got.bad_query !== want.bad_query)
                report($sformatf("result %0d bad_query %0b, expected %0b",
                                 checked_count, got.bad_query, want.bad_query));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    in_item_t            item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_item_t           result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    box_sum_scoreboard   sb;

    // Sender pacing: items go out in bursts, with idle gaps between bursts.
    int unsigned         burst_left   = 0;
    int unsigned         config_writes = 0;

    // Receiver pacing state.
    rx_mode_t            rx_mode      = RX_STEADY;
    int unsigned         rx_mode_left = 0;
    int unsigned         stall_left   = 0;

    integral_image_box_sum_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drives one item and returns at the edge where its transfer completes. Called
    // at a rising edge. Before the item it may close the current burst with a gap;
    // valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input in_item_t it);
        int unsigned gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Query fields are don't-care on a load and the pixel on a query, so they
    // carry random values to show that the block ignores them.
    task automatic send_pixel(input logic [7:0] pixel);
        in_item_t it;

        it            = '0;
        it.top_row    = 6'($urandom());
        it.left_col   = 6'($urandom());
        it.bottom_row = 6'($urandom());
        it.right_col  = 6'($urandom());
        it.op         = OP_LOAD;
        it.pixel      = pixel;
        send_item(it);
    endtask

    task automatic send_query(input int unsigned t, input int unsigned l,
                              input int unsigned b, input int unsigned rc);
        in_item_t it;

        it            = '0;
        it.op         = OP_QUERY;
        it.pixel      = 8'($urandom());
        it.top_row    = 6'(t);
        it.left_col   = 6'(l);
        it.bottom_row = 6'(b);
        it.right_col  = 6'(rc);
        send_item(it);
    endtask

    // Lets every expected result come back, then gives the back end time to go
    // idle so that a register write cannot overlap work in flight.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // where the access transfer completes. Upper data bits are random filler.
    task automatic write_side(input logic [SIDE_W-1:0] side_word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIDE_ADDR;
        pwdata  <= {(PDATA_W - SIDE_W)'($urandom()), side_word};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_side(side_word);
        config_writes++;
    endtask

    // One frame-size setting: loads are forced until the frame is complete, after
    // which the mix is mostly well-formed queries, some rejected ones and a few
    // loads that start the next frame. A saturated phase loads only full-scale
    // pixels, and none once the frame is complete, so that the largest integral
    // values appear, and asks for the whole frame now and then.
    task automatic run_phase(input logic [SIDE_W-1:0] side_word, input int n_items,
                             input bit saturate);
        int unsigned s;
        int unsigned t;
        int unsigned l;
        int unsigned b;
        int unsigned rc;
        int unsigned pick;
        logic [7:0]  pixel;

        write_side(side_word);
        s = sb.side;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (!sb.frame_ready || (!saturate && pick < 8)) begin
                case ($urandom_range(0, 7))
                    0:       pixel = 8'h00;
                    1:       pixel = 8'hFF;
                    default: pixel = 8'($urandom());
                endcase
                send_pixel(saturate ? 8'hFF : pixel);
            end
            else if (saturate && pick < 20) begin
                send_query(0, 0, s - 1, s - 1);
            end
            else if (pick < 28) begin
                // Mostly rejected queries: raw random corners, reversed rows or one corner off the frame.
                t  = $urandom_range(0, 63);
                l  = $urandom_range(0, 63);
                b  = $urandom_range(0, 63);
                rc = $urandom_range(0, 63);
                pick = $urandom_range(0, 2);
                if (pick == 1 && s >= 2) begin
                    t  = $urandom_range(1, s - 1);
                    b  = $urandom_range(0, t - 1);
                    l  = $urandom_range(0, s - 1);
                    rc = $urandom_range(l, s - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        // Swapping roles puts both pairs in order, so the query is legal.
                        {t, b, l, rc} = {l, rc, b, t};
                    end
                end
                else if (pick == 2 && s < TABLE_SIDE) begin
                    t  = $urandom_range(0, s - 1);
                    l  = $urandom_range(0, s - 1);
                    b  = $urandom_range(t, s - 1);
                    rc = $urandom_range(l, s - 1);
                    case ($urandom_range(0, 3))
                        0:       t  = $urandom_range(s, 63);
                        1:       l  = $urandom_range(s, 63);
                        2:       b  = $urandom_range(s, 63);
                        default: rc = $urandom_range(s, 63);
                    endcase
                end
                send_query(t, l, b, rc);
            end
            else begin
                t  = $urandom_range(0, s - 1);
                l  = $urandom_range(0, s - 1);
                b  = $urandom_range(t, s - 1);
                rc = $urandom_range(l, s - 1);
                send_query(t, l, b, rc);
            end
        end
        drain();
    endtask

    // Result side: checks each completed transfer against the oldest prediction,
    // then decides whether to stall next cycle. The stall behavior switches at random
    // intervals between always ready, random, long stalls and toggling.
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            sb.check_result(result);

        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(100, 500);
        end
        else begin
            rx_mode_left--;
        end

        case (rx_mode)
            RX_STEADY:
                result_ready <= 1'b1;
            RX_RANDOM:
                result_ready <= ($urandom_range(0, 9) < 7);
            RX_LONG_STALL:
                if (stall_left > 0) begin
                    stall_left--;
                    result_ready <= 1'b0;
                end
                else begin
                    result_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 30);
                end
            default:
                result_ready <= ~result_ready;
        endcase
    end

    // Watchdog: any cycle with a transfer on the item, result or configuration
    // channel restarts the count. Reaching the limit means the block has hung.
    initial
    begin : watchdog
        int unsigned idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready)
                || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] timeout: no transfer for %0d cycles, %0d results still expected",
                 $realtime, WATCHDOG_LIMIT, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned  random_items;
        int unsigned  phase_no;
        int unsigned  sel;
        int unsigned  eff_side;
        int unsigned  n_items;
        logic [SIDE_W-1:0] side_word;

        sb = new();
        random_items = 0;
        phase_no     = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Loads at the reset side of 64: the first row accumulates, which it would
        // not do with a side of one.
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        drain();

        // A written side of zero behaves as a one-pixel frame. Every load completes
        // a frame, and the next load starts a new one.
        write_side(7'd0);
        send_pixel(8'h00);
        send_query(0, 0, 0, 0);
        send_pixel(8'hFF);
        send_query(0, 0, 0, 0);
        send_query(0, 0, 0, 1);
        send_query(1, 0, 1, 0);
        drain();

        // Two by two frame: whole frame, a single pixel, reversed rows, reversed
        // columns and a corner far outside the frame.
        write_side(7'd2);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_query(0, 0, 1, 1);
        send_query(1, 1, 1, 1);
        send_query(0, 1, 1, 0);
        send_query(1, 0, 0, 1);
        send_query(0, 1, 1, 0);
        send_query(63, 63, 63, 63);
        drain();

        // The first rows of a full-size frame of full-scale pixels, reached through
        // the all-ones register value: rows must wrap at the table size.
        n_items = 2 * TABLE_SIDE + 8;
        run_phase(7'd127, n_items, 1'b1);
        random_items += n_items;

        // Random settings, mostly small frames.
        while (random_items < RANDOM_ITEMS) begin
            phase_no++;
            if (phase_no == 3) begin
                // Exactly the largest side, left mid-frame by the next write.
                n_items = 40;
                run_phase(7'd64, n_items, 1'b0);
            end
            else begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    side_word = 7'd0;
                else if (sel < 4)
                    side_word = SIDE_W'($urandom_range(9, 16));
                else
                    side_word = SIDE_W'($urandom_range(1, 8));
                eff_side = (side_word == 0) ? 1 : side_word;
                n_items  = eff_side * eff_side + $urandom_range(20, 60);
                run_phase(side_word, n_items, 1'b0);
            end
            random_items += n_items;
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d pixel loads and %0d box queries (%0d rejected)",
                 sb.load_count, sb.query_count, sb.rejected_count);
        $display("over %0d side settings; %0d results compared, %0d mismatches.",
                 config_writes, sb.checked_count, sb.fail_count);
        if (sb.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### integral_image_box_sum_top.f
+incdir+rtl
rtl/iibs_pkg.sv
rtl/iibs_front.sv
rtl/iibs_cmd_queue.sv
rtl/iibs_back.sv
rtl/integral_image_box_sum_top.sv
bench/tb_integral_image_box_sum_top.sv
